[rtl/stm_pkg.sv]
package stm_pkg;

    localparam int VALUE_W          = 64;
    localparam int RANGE_W          = 10;
    localparam int LEN_W            = RANGE_W + 1;
    localparam int K_W              = $clog2(LEN_W);
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int LEVELS_DEF       = 11;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUILD_LEVEL,
        ST_BUILD_RD_A,
        ST_BUILD_RD_B,
        ST_BUILD_WR,
        ST_QUERY_CHECK,
        ST_QUERY_RD_A,
        ST_QUERY_RD_B,
        ST_QUERY_MIN,
        ST_QUERY_OUT
    } stm_state_t;

    // Index of the highest set bit; zero for a zero input.
    function automatic logic [K_W-1:0] floor_log2(input logic [LEN_W-1:0] len);
        logic [K_W-1:0] k;
        k = '0;
        for (int b = 0; b < LEN_W; b++)
        begin
            if (len[b])
            begin
                k = K_W'(b);
            end
        end
        return k;
    endfunction

endpackage

[rtl/stm_if.sv]
interface stm_req_if;
    import stm_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    value_t             elem_value;
    logic               final_element;
    logic [RANGE_W-1:0] range_left;
    logic [RANGE_W-1:0] range_right;

    modport source (
        output valid, req_type, elem_value, final_element, range_left, range_right,
        input  ready
    );

    modport sink (
        input  valid, req_type, elem_value, final_element, range_left, range_right,
        output ready
    );
endinterface

interface stm_res_if;
    import stm_pkg::*;

    logic   valid;
    logic   ready;
    value_t range_minimum;
    logic   query_error;

    modport source (
        output valid, range_minimum, query_error,
        input  ready
    );

    modport sink (
        input  valid, range_minimum, query_error,
        output ready
    );
endinterface

[rtl/stm_min.sv]
module stm_min (
    input  stm_pkg::value_t a,
    input  stm_pkg::value_t b,
    output stm_pkg::value_t y
);
    import stm_pkg::*;

    assign y = (a < b) ? a : b;
endmodule

[rtl/stm_mem.sv]
module stm_mem #(
    parameter int DEPTH  = stm_pkg::LEVELS_DEF * stm_pkg::MAX_ELEMENTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  stm_pkg::value_t   wdata,
    input  logic [ADDR_W-1:0] raddr,
    output stm_pkg::value_t   rdata
);
    import stm_pkg::*;

    value_t mem [DEPTH];
    value_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/stm_seq.sv]
module stm_seq #(
    parameter int MAX_ELEMENTS = stm_pkg::MAX_ELEMENTS_DEF,
    parameter int LEVELS       = stm_pkg::LEVELS_DEF,
    parameter int ADDR_W       = $clog2(LEVELS * MAX_ELEMENTS)
) (
    input  logic              clk,
    input  logic              rst_n,
    stm_req_if.sink           req,
    stm_res_if.source         res,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output stm_pkg::value_t   mem_wdata,
    output logic [ADDR_W-1:0] mem_raddr,
    input  stm_pkg::value_t   mem_rdata,
    output stm_pkg::value_t   min_a,
    input  stm_pkg::value_t   min_y
);
    import stm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int SPAN_W = ((CNT_W > LEVELS) ? CNT_W : LEVELS) + 1;
    localparam logic [ADDR_W-1:0] ROW = ADDR_W'(MAX_ELEMENTS);

    stm_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                table_ready_reg, table_ready_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic                out_valid_reg, out_valid_next;
    value_t              out_min_reg, out_min_next;
    logic                out_err_reg, out_err_next;
    value_t              a_reg, a_next;
    value_t              min_reg, min_next;
    logic [RANGE_W-1:0]  left_reg, left_next;
    logic [RANGE_W-1:0]  right_reg, right_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic                err_reg, err_next;

    logic                accept;
    logic                out_free;
    logic [SPAN_W-1:0]   span;
    logic [SPAN_W-1:0]   half;
    logic [IDX_W-1:0]    i_inc;
    logic                level_go;
    logic                build_more;
    logic [LEN_W-1:0]    q_len;
    logic [K_W-1:0]      q_k;
    logic                q_err;
    logic [ADDR_W-1:0]   k_base;
    logic [LEN_W-1:0]    off_b;
    logic [ADDR_W-1:0]   rd_a_addr;
    logic [CNT_W-1:0]    eff_count;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || res.ready;

    assign span       = SPAN_W'(1) << lvl_reg;
    assign half       = span >> 1;
    assign i_inc      = i_reg + IDX_W'(1);
    assign level_go   = (int'(lvl_reg) < LEVELS) && (span <= SPAN_W'(count_reg));
    assign build_more = (SPAN_W'(i_inc) + span) <= SPAN_W'(count_reg);
    assign rd_a_addr  = base_reg - ROW + ADDR_W'(i_reg);

    assign q_len  = {1'b0, right_reg} - {1'b0, left_reg} + LEN_W'(1);
    assign q_k    = floor_log2(q_len);
    assign q_err  = !table_ready_reg || (left_reg > right_reg)
                  || (32'(right_reg) >= 32'(count_reg)) || (int'(q_k) >= LEVELS);
    assign k_base = ADDR_W'(int'(k_reg) * MAX_ELEMENTS);
    assign off_b  = {1'b0, right_reg} + LEN_W'(1) - (LEN_W'(1) << k_reg);

    assign eff_count = table_ready_reg ? '0 : count_reg;

    assign req.ready         = (state_reg == ST_IDLE);
    assign res.valid         = out_valid_reg;
    assign res.range_minimum = out_min_reg;
    assign res.query_error   = out_err_reg;
    assign min_a             = a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            table_ready_reg <= 1'b0;
            lvl_reg         <= '0;
            i_reg           <= '0;
            base_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            table_ready_reg <= table_ready_next;
            lvl_reg         <= lvl_next;
            i_reg           <= i_next;
            base_reg        <= base_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_min_reg <= out_min_next;
        out_err_reg <= out_err_next;
        a_reg       <= a_next;
        min_reg     <= min_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        k_reg       <= k_next;
        err_reg     <= err_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_QUERY)
                    begin
                        state_next = ST_QUERY_CHECK;
                    end
                    else if (req.final_element)
                    begin
                        state_next = ST_BUILD_LEVEL;
                    end
                end
            end
            ST_BUILD_LEVEL: state_next = level_go ? ST_BUILD_RD_A : ST_IDLE;
            ST_BUILD_RD_A:  state_next = ST_BUILD_RD_B;
            ST_BUILD_RD_B:  state_next = ST_BUILD_WR;
            ST_BUILD_WR:    state_next = build_more ? ST_BUILD_RD_A : ST_BUILD_LEVEL;
            ST_QUERY_CHECK: state_next = q_err ? ST_QUERY_OUT : ST_QUERY_RD_A;
            ST_QUERY_RD_A:  state_next = ST_QUERY_RD_B;
            ST_QUERY_RD_B:  state_next = ST_QUERY_MIN;
            ST_QUERY_MIN:   state_next = ST_QUERY_OUT;
            ST_QUERY_OUT:   state_next = out_free ? ST_IDLE : ST_QUERY_OUT;
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next       = count_reg;
        table_ready_next = table_ready_reg;
        lvl_next         = lvl_reg;
        i_next           = i_reg;
        base_next        = base_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_min_next     = out_min_reg;
        out_err_next     = out_err_reg;
        a_next           = a_reg;
        min_next         = min_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        k_next           = k_reg;
        err_next         = err_reg;
        mem_we           = 1'b0;
        mem_waddr        = ADDR_W'(eff_count);
        mem_wdata        = req.elem_value;
        mem_raddr        = rd_a_addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_LOAD)
                    begin
                        // A load after a build starts a fresh array.
                        table_ready_next = 1'b0;
                        count_next       = eff_count;
                        if (eff_count < CNT_W'(MAX_ELEMENTS))
                        begin
                            mem_we     = 1'b1;
                            count_next = eff_count + CNT_W'(1);
                        end
                        if (req.final_element)
                        begin
                            lvl_next  = LVL_W'(1);
                            base_next = ROW;
                        end
                    end
                    else
                    begin
                        left_next  = req.range_left;
                        right_next = req.range_right;
                    end
                end
            end
            ST_BUILD_LEVEL:
            begin
                i_next = '0;
                if (!level_go)
                begin
                    table_ready_next = 1'b1;
                end
            end
            ST_BUILD_RD_A:
            begin
                mem_raddr = rd_a_addr;
            end
            ST_BUILD_RD_B:
            begin
                mem_raddr = rd_a_addr + ADDR_W'(half);
                a_next    = mem_rdata;
            end
            ST_BUILD_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = base_reg + ADDR_W'(i_reg);
                mem_wdata = min_y;
                if (build_more)
                begin
                    i_next = i_inc;
                end
                else
                begin
                    lvl_next  = lvl_reg + LVL_W'(1);
                    base_next = base_reg + ROW;
                end
            end
            ST_QUERY_CHECK:
            begin
                k_next   = q_k;
                err_next = q_err;
            end
            ST_QUERY_RD_A:
            begin
                mem_raddr = k_base + ADDR_W'(left_reg);
            end
            ST_QUERY_RD_B:
            begin
                mem_raddr = k_base + ADDR_W'(off_b);
                a_next    = mem_rdata;
            end
            ST_QUERY_MIN:
            begin
                min_next = min_y;
            end
            ST_QUERY_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_min_next   = err_reg ? '0 : min_reg;
                    out_err_next   = err_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end
endmodule

[rtl/sparse_table_range_min.sv]
// Range-minimum engine over signed 64-bit values. Load requests write the array one element
// per cycle from index 0; the load flagged final starts a table build that fills the levels
// one after another, every entry needing two reads through the single read port of the
// table memory and then one write. A load after a build starts a new array, and elements
// beyond the capacity are dropped. A query goes through a check, two table reads, a minimum
// and an output step, or from the check straight to output when rejected, and waits there
// until the output register is free; it returns the minimum over the inclusive range from
// two overlapping power-of-two windows. A query before a build, with left above right, with
// right at or beyond the element count or needing a level beyond LEVELS returns zero with
// the error flag set. The block takes no request while a build or a query is in progress.
module sparse_table_range_min #(
    parameter int MAX_ELEMENTS = stm_pkg::MAX_ELEMENTS_DEF,
    parameter int LEVELS       = stm_pkg::LEVELS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    stm_req_if.sink   req,
    stm_res_if.source res
);
    import stm_pkg::*;

    localparam int DEPTH  = LEVELS * MAX_ELEMENTS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    value_t            mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    value_t            mem_rdata;
    value_t            min_a;
    value_t            min_y;

    stm_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS),
        .ADDR_W       (ADDR_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .min_a     (min_a),
        .min_y     (min_y)
    );

    stm_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    stm_min u_min (
        .a (min_a),
        .b (mem_rdata),
        .y (min_y)
    );
endmodule
